FILE: hdl/pdus_pkg.sv
`default_nettype none
package pdus_pkg;

	localparam int MAX_DATES  = 64;
	localparam int DATE_BITS  = 15;
	localparam int WORD_BITS  = 32;
	localparam int WORD_DEPTH = (MAX_DATES * DATE_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int CNT_W      = $clog2(MAX_DATES) + 1;
	localparam int DIDX_W     = $clog2(MAX_DATES);
	localparam int WIDX_W     = $clog2(WORD_DEPTH);
	localparam int POS_W      = $clog2(MAX_DATES * DATE_BITS);
	localparam logic [10:0] YEAR_BASE = 11'd1970;

	localparam logic [0:0] REG_DATE_COUNT  = 1'b0;
	localparam logic [0:0] REG_PACKED_MODE = 1'b1;

	typedef struct packed {
		logic [6:0] date_count;
		logic       packed_mode;
	} cfg_t;

	typedef enum logic [1:0] {
		K_PLAIN,
		K_DATA,
		K_CTRL
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [WIDX_W-1:0] idx;
		logic              fin;
		logic [31:0]       w;
	} qent_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_INS,
		B_INS_CMP,
		B_GA_LO,
		B_GA_HI,
		B_GA_MK,
		B_EMIT_RD,
		B_EMIT_WAIT,
		B_EMIT_OUT
	} bstate_t;

	function automatic logic [CNT_W-1:0] eff_count(input logic [6:0] dc);
		logic [CNT_W-1:0] r;
		if (dc > 7'(MAX_DATES)) r = CNT_W'(MAX_DATES);
		else r = CNT_W'(dc);
		return r;
	endfunction

	function automatic logic [WIDX_W:0] data_words(input logic [CNT_W-1:0] n);
		logic [POS_W+1:0] t;
		t = (POS_W+2)'(n) * (POS_W+2)'(DATE_BITS) + (POS_W+2)'(WORD_BITS - 1);
		return (WIDX_W+1)'(t >> 5);
	endfunction

endpackage
`default_nettype wire

FILE: hdl/packed_date_unpack_sort_top.sv
// Packed date unpack and sort.
// Configure date_count (address 0) and packed_mode (address 4) over the APB
// port while the block is idle; any write starts a fresh batch.
// Input beats on word/in_valid/in_ready: with n = date_count capped at 64,
// plain mode takes n words, packed mode ceil(15*n/32) data words and one
// control word of even-parity bits. A batch of zero dates swallows every word.
// Words pass through a two-entry queue to the back end, which stores them,
// checks parity and insertion-sorts kept dates into a 64-entry date memory.
// A plain word's insertion time grows with the number of stored dates it moves
// past; a packed date is first unpacked in the gather states GA_LO, GA_HI and
// GA_MK, then inserted the same way. Words are accepted while the queue has room.
// After the last word, the sorted dates come out on day/month/year/last with
// out_valid/out_ready, one date at a time through read, wait and output; last marks the
// final date. If the receiver stalls, the beat holds and the back end waits;
// the front keeps taking words until the queue fills.
// Reset clears the state, counters and handshake state; the payload registers,
// flags and stores are written before they are read and need no clearing.
`default_nettype none
module packed_date_unpack_sort_top
	import pdus_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] word,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [4:0]       day,
	output logic [3:0]       month,
	output logic [10:0]      year,
	output logic             last
);
	cfg_t  cfg_q;
	logic  cfg_wr, q_push, q_pop, q_valid, q_full;
	qent_t q_in, q_out;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[2])
			REG_DATE_COUNT:  prdata = {25'd0, cfg_q.date_count};
			REG_PACKED_MODE: prdata = {31'd0, cfg_q.packed_mode};
			default:         prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_DATE_COUNT:  cfg_q.date_count  <= pwdata[6:0];
				REG_PACKED_MODE: cfg_q.packed_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	pdus_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clr      (cfg_wr),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.word     (word),
		.q_full   (q_full),
		.push     (q_push),
		.ent      (q_in)
	);

	pdus_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_in),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_out),
		.full   (q_full)
	);

	pdus_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.clr       (cfg_wr),
		.q_valid   (q_valid),
		.q_ent     (q_out),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.day       (day),
		.month     (month),
		.year      (year),
		.last      (last)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue read while empty");
	a_emit_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !q_pop) else $error("back end took a word while emitting");
`endif
endmodule
`default_nettype wire

FILE: hdl/pdus_queue.sv
`default_nettype none
module pdus_queue
	import pdus_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire qent_t din,
	input  wire logic  pop,
	output logic       valid,
	output qent_t      dout,
	output logic       full
);
	qent_t       ent_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;

	assign valid = (cnt_q != 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign dout  = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

FILE: hdl/pdus_front.sv
`default_nettype none
module pdus_front
	import pdus_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        clr,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] word,
	input  wire logic        q_full,
	output logic             push,
	output qent_t            ent
);
	logic [CNT_W-1:0]  n;
	logic [WIDX_W:0]   dw;
	logic [CNT_W-1:0]  total;
	logic [CNT_W-1:0]  cnt_q;
	logic              empty_batch;

	assign n     = eff_count(cfg.date_count);
	assign dw    = data_words(n);
	assign total = cfg.packed_mode ? CNT_W'(dw) + CNT_W'(dw != '0) : n;
	assign empty_batch = (total == '0);

	// With an empty batch every word is taken and dropped.
	assign in_ready = empty_batch || !q_full;
	assign push     = in_valid && in_ready && !empty_batch;

	always_comb begin
		ent.w   = word;
		ent.idx = cnt_q[WIDX_W-1:0];
		ent.fin = (cnt_q + CNT_W'(1) == total);
		if (!cfg.packed_mode) ent.kind = K_PLAIN;
		else if (cnt_q < CNT_W'(dw)) ent.kind = K_DATA;
		else ent.kind = K_CTRL;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clr) begin
			cnt_q <= '0;
		end else if (push) begin
			cnt_q <= ent.fin ? '0 : cnt_q + CNT_W'(1);
		end
	end
endmodule
`default_nettype wire

FILE: hdl/pdus_back.sv
`default_nettype none
module pdus_back
	import pdus_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   clr,
	input  wire logic   q_valid,
	input  wire qent_t  q_ent,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_ready,
	output logic [4:0]  day,
	output logic [3:0]  month,
	output logic [10:0] year,
	output logic        last
);
	logic [31:0]          word_mem [WORD_DEPTH];
	logic [DATE_BITS-1:0] date_mem [MAX_DATES];

	bstate_t              st_q, st_d;
	logic [DIDX_W-1:0]    j_q, k_q, i_q;
	logic [DATE_BITS-1:0] v_q;
	logic [CNT_W-1:0]     kept_q, n;
	logic                 gath_q, fin_q;
	logic [POS_W-1:0]     pos_q, pos14;
	logic [31:0]          lo_q, word_rd_q, hi;
	logic [DATE_BITS-1:0] date_rd_q, gv;
	logic [WORD_DEPTH-1:0] par_q, good_q;
	logic [WIDX_W-1:0]    first, lastw, first1, word_raddr;
	logic [4:0]           off;
	logic [63:0]          pair;
	logic [DIDX_W-1:0]    date_raddr, date_waddr;
	logic [DATE_BITS-1:0] date_wdata;
	logic                 date_we, gt, ins_done, keep, last_date, emit_last;

	assign n      = eff_count(cfg.date_count);
	assign first  = pos_q[POS_W-1:5];
	assign off    = pos_q[4:0];
	assign pos14  = pos_q + POS_W'(DATE_BITS - 1);
	assign lastw  = pos14[POS_W-1:5];
	assign first1 = (first == WIDX_W'(WORD_DEPTH - 1)) ? first : first + WIDX_W'(1);
	assign hi     = (lastw == first) ? 32'd0 : word_rd_q;
	assign pair   = {hi, lo_q} >> off;
	assign gv     = pair[DATE_BITS-1:0];
	assign keep   = good_q[first] && good_q[lastw];
	assign gt     = date_rd_q > v_q;
	assign last_date = ({1'b0, i_q} + CNT_W'(1) == n);
	assign emit_last = ({1'b0, k_q} + CNT_W'(1) == kept_q);
	assign ins_done  = (st_q == B_INS && j_q == '0) || (st_q == B_INS_CMP && !gt);

	// Next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			B_IDLE: begin
				if (q_valid) begin
					case (q_ent.kind)
						K_PLAIN: st_d = B_INS;
						K_CTRL:  st_d = B_GA_LO;
						default: st_d = B_IDLE;
					endcase
				end
			end
			B_INS, B_INS_CMP: begin
				if (st_q == B_INS && j_q != '0) st_d = B_INS_CMP;
				else if (st_q == B_INS_CMP && gt) st_d = B_INS;
				else if (gath_q) st_d = last_date ? B_EMIT_RD : B_GA_LO;
				else st_d = fin_q ? B_EMIT_RD : B_IDLE;
			end
			B_GA_LO: st_d = B_GA_HI;
			B_GA_HI: st_d = B_GA_MK;
			B_GA_MK: begin
				if (keep) st_d = B_INS;
				else if (!last_date) st_d = B_GA_LO;
				else st_d = (kept_q == '0) ? B_IDLE : B_EMIT_RD;
			end
			B_EMIT_RD:   st_d = B_EMIT_WAIT;
			B_EMIT_WAIT: st_d = B_EMIT_OUT;
			B_EMIT_OUT: begin
				if (out_ready) st_d = emit_last ? B_IDLE : B_EMIT_RD;
			end
			default: st_d = B_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		pop        = (st_q == B_IDLE) && q_valid;
		word_raddr = (st_q == B_GA_HI) ? first1 : first;
		date_raddr = (st_q == B_EMIT_RD) ? k_q : j_q - DIDX_W'(1);
		date_we    = (st_q == B_INS && j_q == '0) || (st_q == B_INS_CMP);
		date_waddr = j_q;
		date_wdata = (st_q == B_INS_CMP && gt) ? date_rd_q : v_q;
	end

	always_ff @(posedge clk) begin
		word_rd_q <= word_mem[word_raddr];
		date_rd_q <= date_mem[date_raddr];
		if (pop && q_ent.kind == K_DATA) word_mem[q_ent.idx] <= q_ent.w;
		if (date_we) date_mem[date_waddr] <= date_wdata;
	end

	// Payload and per-word flags; none of these need a reset.
	always_ff @(posedge clk) begin
		if (pop) begin
			v_q   <= q_ent.w[DATE_BITS-1:0];
			j_q   <= kept_q[DIDX_W-1:0];
			fin_q <= q_ent.fin;
			if (q_ent.kind == K_DATA) par_q[q_ent.idx] <= ^q_ent.w;
			if (q_ent.kind == K_CTRL) good_q <= ~(par_q ^ q_ent.w[WORD_DEPTH-1:0]);
		end
		if (st_q == B_INS_CMP && gt) j_q <= j_q - DIDX_W'(1);
		if (st_q == B_GA_HI) lo_q <= word_rd_q;
		if (st_q == B_GA_MK && keep) begin
			v_q <= gv;
			j_q <= kept_q[DIDX_W-1:0];
		end
		if (st_q == B_EMIT_WAIT) begin
			day   <= date_rd_q[4:0];
			month <= date_rd_q[8:5];
			year  <= YEAR_BASE + 11'(date_rd_q[14:9]);
			last  <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= B_IDLE;
			kept_q    <= '0;
			gath_q    <= 1'b0;
			i_q       <= '0;
			pos_q     <= '0;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop) begin
				gath_q <= (q_ent.kind == K_CTRL);
				i_q    <= '0;
				pos_q  <= '0;
			end
			// A register write drops the dates of an unfinished batch.
			if (clr || (st_q == B_EMIT_OUT && out_ready && emit_last)) kept_q <= '0;
			else if (ins_done) kept_q <= kept_q + CNT_W'(1);
			if ((ins_done && gath_q) || (st_q == B_GA_MK && !keep)) begin
				i_q   <= i_q + DIDX_W'(1);
				pos_q <= pos_q + POS_W'(DATE_BITS);
			end
			if (st_d == B_EMIT_RD && st_q != B_EMIT_OUT) k_q <= '0;
			if (st_q == B_EMIT_WAIT) out_valid <= 1'b1;
			if (st_q == B_EMIT_OUT && out_ready) begin
				out_valid <= 1'b0;
				if (!emit_last) k_q <= k_q + DIDX_W'(1);
			end
		end
	end
endmodule
`default_nettype wire
